// ===== sv/dta_pkg.sv =====
// Package for the descriptor table allocator: sizes, operation and status codes,
// sequencer states and the free-slot priority encoder.
// No dependencies.
package dta_pkg;

    localparam int MAX_FD    = 64;
    localparam int IDX_W     = $clog2(MAX_FD);
    localparam int HANDLE_W  = 32;
    localparam int COUNT_W   = 8;
    localparam int RES_IDX_W = 7;

    typedef logic [IDX_W-1:0]    t_slot;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [COUNT_W-1:0]  t_count;

    typedef enum logic [2:0] {
        MODE_ALLOC = 3'd0,
        MODE_GET   = 3'd1,
        MODE_FREE  = 3'd2,
        MODE_DUP   = 3'd3,
        MODE_CLOSE = 3'd4,
        MODE_STD   = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_BADFD = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_STD,
        S_RESP
    } t_state;

    localparam logic signed [7:0] DUP_ANY = -8'sd1;
    localparam logic [MAX_FD-1:0] RESERVED_SLOTS = MAX_FD'(7);
    localparam t_count COUNT_MAX = '1;

    typedef struct packed {
        logic  found;
        t_slot idx;
    } t_find;

    // Priority encoder: lowest clear bit of the used vector.
    function automatic t_find find_free(logic [MAX_FD-1:0] used);
        t_find r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = MAX_FD - 1; i >= 0; i--) begin
            if (!used[i]) begin
                r.found = 1'b1;
                r.idx   = IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic in_range(logic signed [7:0] v);
        return (v[7] == 1'b0) && ($unsigned(v) < 8'(MAX_FD));
    endfunction

    function automatic t_count count_up(t_count c, logic [1:0] n);
        logic [COUNT_W:0] s;
        s = {1'b0, c} + (COUNT_W + 1)'(n);
        return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

    function automatic t_count count_down(t_count c);
        return (c != '0) ? c - t_count'(1) : c;
    endfunction

endpackage

// ===== sv/dta_if.sv =====
// Request and response channel interfaces of the descriptor table allocator.
// Depends on dta_pkg.
interface dta_req_if import dta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    t_handle           handle;
    t_handle           second_handle;
    t_handle           third_handle;
    logic signed [7:0] slot_index;
    logic signed [7:0] target_index;

    modport source (output valid, mode, handle, second_handle, third_handle,
                    slot_index, target_index, input ready);
    modport sink   (input valid, mode, handle, second_handle, third_handle,
                    slot_index, target_index, output ready);
endinterface

interface dta_rsp_if import dta_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [RES_IDX_W-1:0] result_index;
    t_handle              read_handle;
    t_count               open_total;

    modport source (output valid, status, result_index, read_handle, open_total,
                    input ready);
    modport sink   (input valid, status, result_index, read_handle, open_total,
                    output ready);
endinterface

// ===== sv/descriptor_table_allocator_top.sv =====
// Descriptor table allocator: request channel in, one response per request out.
// Depends on dta_pkg and dta_if (dta_req_if, dta_rsp_if).
//
// Usage:
//   i_req carries one operation (alloc, get, free, dup, close all, set standard);
//   o_rsp returns status, assigned descriptor, read handle and the open count.
//   Transactions complete on valid && ready.
// Timing:
//   The block handles one transaction at a time. The request cycle issues the
//   handle memory read, the next cycle evaluates and writes back, and for most
//   operations the response is shown the cycle after; set standard first writes
//   slots 1 and 2 in S_STD (one memory write port, three slots).
//   A new request is taken the cycle after the response is taken.
//   The lowest free slot comes from a priority encoder over per-slot valid bits.
// Reset:
//   Synchronous, active low; all slots read as empty (valid bits cleared at
//   once) and the open count is zero. No clearing pass.
// Stall:
//   While o_rsp.ready is low the response is held and no request is taken.
module descriptor_table_allocator_top import dta_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dta_req_if.sink   i_req,
    dta_rsp_if.source o_rsp
);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    t_handle r_h0, n_h0, r_h1, n_h1, r_h2, n_h2;
    logic signed [7:0] r_src, n_src, r_tgt, n_tgt;
    logic [1:0] r_step, n_step;
    logic [MAX_FD-1:0] r_valid, n_valid;
    t_count r_count, n_count;
    t_status r_status, n_status;
    logic [RES_IDX_W-1:0] r_idx, n_idx;
    t_handle r_rd, n_rd;

    t_handle r_mem [MAX_FD];
    t_handle r_rd_data;
    logic    we;
    t_slot   waddr;
    t_handle wdata;

    t_handle src_h;
    logic    src_ok;
    t_find   ff_alloc, ff_dup;
    t_slot   src_slot, tgt_slot, std_slot;
    t_handle std_h;
    logic    accept;

    assign accept   = i_req.valid && i_req.ready;
    assign src_slot = r_src[IDX_W-1:0];
    assign tgt_slot = r_tgt[IDX_W-1:0];
    assign src_ok   = in_range(r_src) && r_valid[src_slot];
    assign src_h    = src_ok ? r_rd_data : '0;
    assign ff_alloc = find_free(r_valid | RESERVED_SLOTS);
    assign ff_dup   = find_free(r_valid);
    assign std_slot = IDX_W'(r_step);
    assign std_h    = (r_step == 2'd1) ? r_h1 : r_h2;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_mem[i_req.slot_index[IDX_W-1:0]];
        end
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
            r_step  <= n_step;
        end
        r_mode   <= n_mode;
        r_h0     <= n_h0;
        r_h1     <= n_h1;
        r_h2     <= n_h2;
        r_src    <= n_src;
        r_tgt    <= n_tgt;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_rd     <= n_rd;
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_h0     = r_h0;
        n_h1     = r_h1;
        n_h2     = r_h2;
        n_src    = r_src;
        n_tgt    = r_tgt;
        n_step   = r_step;
        n_valid  = r_valid;
        n_count  = r_count;
        n_status = r_status;
        n_idx    = r_idx;
        n_rd     = r_rd;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        i_req.ready = 1'b0;
        o_rsp.valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_mode  = t_mode'(i_req.mode);
                    n_h0    = i_req.handle;
                    n_h1    = i_req.second_handle;
                    n_h2    = i_req.third_handle;
                    n_src   = i_req.slot_index;
                    n_tgt   = i_req.target_index;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_idx    = '0;
                n_rd     = '0;
                n_state  = S_RESP;
                case (r_mode)
                    MODE_ALLOC: begin
                        if (r_h0 == '0) begin
                            n_status = ST_INVAL;
                        end else if (!ff_alloc.found) begin
                            n_status = ST_FULL;
                        end else begin
                            we = 1'b1;
                            waddr = ff_alloc.idx;
                            wdata = r_h0;
                            n_valid[ff_alloc.idx] = 1'b1;
                            n_count = count_up(r_count, 2'd1);
                            n_idx = RES_IDX_W'(ff_alloc.idx);
                        end
                    end
                    MODE_GET: begin
                        n_rd = src_h;
                    end
                    MODE_FREE: begin
                        if (!src_ok) begin
                            n_status = ST_BADFD;
                        end else begin
                            n_valid[src_slot] = 1'b0;
                            n_count = count_down(r_count);
                        end
                    end
                    MODE_DUP: begin
                        if (!src_ok) begin
                            n_status = ST_BADFD;
                        end else if (in_range(r_tgt)) begin
                            we = 1'b1;
                            waddr = tgt_slot;
                            wdata = src_h;
                            n_valid[tgt_slot] = 1'b1;
                            n_count = count_up(r_valid[tgt_slot] ? count_down(r_count)
                                                                 : r_count, 2'd1);
                            n_idx = RES_IDX_W'(tgt_slot);
                        end else if (r_tgt == DUP_ANY && ff_dup.found) begin
                            we = 1'b1;
                            waddr = ff_dup.idx;
                            wdata = src_h;
                            n_valid[ff_dup.idx] = 1'b1;
                            n_count = count_up(r_count, 2'd1);
                            n_idx = RES_IDX_W'(ff_dup.idx);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                    MODE_CLOSE: begin
                        n_valid = '0;
                        n_count = '0;
                    end
                    MODE_STD: begin
                        we = 1'b1;
                        waddr = '0;
                        wdata = r_h0;
                        n_valid[0] = (r_h0 != '0);
                        n_count = count_up(r_count, 2'd3);
                        n_step = 2'd1;
                        n_state = S_STD;
                    end
                    default: begin
                        n_status = ST_INVAL;
                    end
                endcase
            end
            S_STD: begin
                we = 1'b1;
                waddr = std_slot;
                wdata = std_h;
                n_valid[std_slot] = (std_h != '0);
                if (r_step == 2'd2) begin
                    n_step  = '0;
                    n_state = S_RESP;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_RESP: begin
                o_rsp.valid = 1'b1;
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.status       = r_status;
    assign o_rsp.result_index = r_idx;
    assign o_rsp.read_handle  = r_rd;
    assign o_rsp.open_total   = r_count;

endmodule

// ===== sv/dta_check.sv =====
// Port-level checker for the descriptor table allocator, bound to the top level.
// Depends on dta_pkg and descriptor_table_allocator_top.
module dta_check import dta_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [1:0]           i_status,
    input logic [RES_IDX_W-1:0] i_result_index,
    input t_handle              i_read_handle,
    input t_count               i_open_total
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // One transaction in flight: never ready while a response is shown.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("request ready while response pending");

    a_no_same_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_out_valid)
        else $error("response one cycle after request");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_OK) |-> (i_result_index == '0 && i_read_handle == '0))
        else $error("error response carries data");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_result_index)
             && $stable(i_read_handle) && $stable(i_open_total)))
        else $error("stalled response changed");

endmodule

bind descriptor_table_allocator_top dta_check u_dta_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_result_index (o_rsp.result_index),
    .i_read_handle  (o_rsp.read_handle),
    .i_open_total   (o_rsp.open_total)
);

// ===== tb/descriptor_table_allocator_top_tb.sv =====
// Self-checking testbench for descriptor_table_allocator_top: a directed set of
// table operations, then random traffic, checked against a shadow of the table.
// Depends on dta_pkg, dta_if and the top level.
module descriptor_table_allocator_top_tb;
    import dta_pkg::*;

    localparam int FIRST_USER_SLOT = 3;
    localparam int SIDE_REQ        = 0;
    localparam int SIDE_RSP        = 1;
    localparam int RANDOM_OPS      = 1000;
    localparam int MAX_REPORTS     = 10;

    // Mode codes the block does not define.
    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    typedef struct {
        logic [2:0]        mode;
        t_handle           h0;
        t_handle           h1;
        t_handle           h2;
        logic signed [7:0] src;
        logic signed [7:0] tgt;
    } t_table_op;

    typedef struct packed {
        t_status              status;
        logic [RES_IDX_W-1:0] index;
        t_handle              rd;
        t_count               total;
    } t_table_reply;

    logic i_clk;
    logic i_rst_n;

    dta_req_if req_bus ();
    dta_rsp_if rsp_bus ();

    descriptor_table_allocator_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_table_op    pending_ops[$];
    t_table_reply reply_q[$];
    t_handle      table_shadow[MAX_FD];
    t_count       open_shadow;

    logic req_taken;
    logic rsp_taken;
    int   req_gap;
    int   rsp_stall;
    int   quiet_left[2];
    int   n_req;
    int   n_rsp;
    int   n_full;
    int   n_at_max;
    int   mismatches;

    always #5 i_clk = ~i_clk;

    // ---------------- shadow table ----------------
    function automatic int lowest_empty(int from);
        for (int i = from; i < MAX_FD; i++)
            if (table_shadow[i] == '0)
                return i;
        return -1;
    endfunction

    function automatic void count_add(int n);
        int s;
        s = int'(open_shadow) + n;
        open_shadow = (s > int'(COUNT_MAX)) ? COUNT_MAX : t_count'(s);
    endfunction

    function automatic void count_sub();
        if (open_shadow != '0)
            open_shadow = open_shadow - t_count'(1);
    endfunction

    function automatic t_table_reply apply_table_op(t_table_op op);
        t_table_reply r;
        int           s;
        int           t;
        int           f;
        t_handle      h;
        r.status = ST_OK;
        r.index  = '0;
        r.rd     = '0;
        s = op.src;
        t = op.tgt;
        case (op.mode)
            MODE_ALLOC: begin
                f = lowest_empty(FIRST_USER_SLOT);
                if (op.h0 == '0) begin
                    r.status = ST_INVAL;
                end else if (f < 0) begin
                    r.status = ST_FULL;
                end else begin
                    table_shadow[f] = op.h0;
                    count_add(1);
                    r.index = RES_IDX_W'(f);
                end
            end
            MODE_GET: begin
                if (s >= 0 && s < MAX_FD)
                    r.rd = table_shadow[s];
            end
            MODE_FREE: begin
                if (s < 0 || s >= MAX_FD || table_shadow[s] == '0) begin
                    r.status = ST_BADFD;
                end else begin
                    table_shadow[s] = '0;
                    count_sub();
                end
            end
            MODE_DUP: begin
                if (s < 0 || s >= MAX_FD || table_shadow[s] == '0) begin
                    r.status = ST_BADFD;
                end else begin
                    h = table_shadow[s];
                    if (t >= 0 && t < MAX_FD) begin
                        if (table_shadow[t] != '0) begin
                            table_shadow[t] = '0;
                            count_sub();
                        end
                        table_shadow[t] = h;
                        count_add(1);
                        r.index = RES_IDX_W'(t);
                    end else if (op.tgt == DUP_ANY) begin
                        f = lowest_empty(0);
                        if (f < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            table_shadow[f] = h;
                            count_add(1);
                            r.index = RES_IDX_W'(f);
                        end
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
            MODE_CLOSE: begin
                foreach (table_shadow[i])
                    table_shadow[i] = '0;
                open_shadow = '0;
            end
            MODE_STD: begin
                table_shadow[0] = op.h0;
                table_shadow[1] = op.h1;
                table_shadow[2] = op.h2;
                count_add(3);
            end
            default: r.status = ST_INVAL;
        endcase
        r.total = open_shadow;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    task automatic push_op(logic [2:0] m, t_handle a, t_handle b, t_handle c,
                           logic signed [7:0] s, logic signed [7:0] t);
        t_table_op op;
        op.mode = m;
        op.h0   = a;
        op.h1   = b;
        op.h2   = c;
        op.src  = s;
        op.tgt  = t;
        pending_ops.push_back(op);
    endtask

    function automatic t_handle any_handle();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic t_handle nz_handle();
        t_handle h;
        h = $urandom;
        return (h == '0) ? t_handle'(1) : h;
    endfunction

    function automatic logic signed [7:0] any_slot();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 8'($urandom_range(0, 15));
        if (r < 85)
            return 8'($urandom_range(0, MAX_FD - 1));
        return 8'($urandom);
    endfunction

    function automatic logic signed [7:0] any_target();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return DUP_ANY;
        if (r < 75)
            return any_slot();
        return 8'($urandom);
    endfunction

    task automatic fill_table_burst();
        push_op(MODE_STD, nz_handle(), nz_handle(), nz_handle(), 0, 0);
        for (int k = 0; k < MAX_FD - 1; k++)
            push_op(MODE_ALLOC, nz_handle(), 0, 0, 0, 0);
        push_op(MODE_DUP, 0, 0, 0, 8'($urandom_range(0, MAX_FD - 1)), DUP_ANY);
        push_op(MODE_DUP, 0, 0, 0, 8'($urandom_range(0, MAX_FD - 1)), DUP_ANY);
        push_op(MODE_ALLOC, 0, 0, 0, 0, 0);
        for (int k = 0; k < 6; k++) begin
            push_op(MODE_FREE, 0, 0, 0, 8'($urandom_range(0, MAX_FD - 1)), 0);
            push_op(MODE_ALLOC, nz_handle(), 0, 0, 0, 0);
        end
    endtask

    task automatic saturate_count_burst();
        for (int k = 0; k < 88; k++)
            push_op(MODE_STD, any_handle(), any_handle(), any_handle(), 0, 0);
        for (int k = 0; k < 4; k++)
            push_op(MODE_FREE, 0, 0, 0, any_slot(), 0);
    endtask

    task automatic random_op();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            push_op(MODE_ALLOC, ($urandom_range(9) == 0) ? t_handle'(0) : nz_handle(),
                    any_handle(), any_handle(), 8'($urandom), 8'($urandom));
        else if (r < 48)
            push_op(MODE_GET, any_handle(), any_handle(), any_handle(), any_slot(),
                    8'($urandom));
        else if (r < 66)
            push_op(MODE_FREE, any_handle(), any_handle(), any_handle(), any_slot(),
                    8'($urandom));
        else if (r < 86)
            push_op(MODE_DUP, any_handle(), any_handle(), any_handle(), any_slot(),
                    any_target());
        else if (r < 91)
            push_op(MODE_STD, any_handle(), any_handle(), any_handle(), 8'($urandom),
                    8'($urandom));
        else if (r < 95)
            push_op(MODE_CLOSE, any_handle(), any_handle(), any_handle(), 8'($urandom),
                    8'($urandom));
        else
            push_op(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), any_handle(),
                    any_handle(), any_handle(), 8'($urandom), 8'($urandom));
    endtask

    task automatic build_stimulus();
        push_op(MODE_ALLOC, 0, 0, 0, 0, 0);
        push_op(MODE_GET, 0, 0, 0, 5, 0);
        push_op(MODE_ALLOC, 32'hFFFF_FFFF, 0, 0, 0, 0);
        push_op(MODE_ALLOC, 32'h0000_0001, 0, 0, 0, 0);
        push_op(MODE_GET, 0, 0, 0, 3, 0);
        push_op(MODE_GET, 0, 0, 0, -8'sd128, 0);
        push_op(MODE_GET, 0, 0, 0, 8'sd127, 0);
        push_op(MODE_GET, 0, 0, 0, 8'(MAX_FD), 0);
        push_op(MODE_FREE, 0, 0, 0, -8'sd1, 0);
        push_op(MODE_FREE, 0, 0, 0, 8'(MAX_FD - 1), 0);
        push_op(MODE_FREE, 0, 0, 0, 4, 0);
        push_op(MODE_DUP, 0, 0, 0, 4, 5);
        push_op(MODE_DUP, 0, 0, 0, -8'sd128, 5);
        push_op(MODE_DUP, 0, 0, 0, 3, DUP_ANY);
        push_op(MODE_DUP, 0, 0, 0, 3, 3);
        push_op(MODE_DUP, 0, 0, 0, 3, 8'(MAX_FD - 1));
        push_op(MODE_DUP, 0, 0, 0, 3, 0);
        push_op(MODE_DUP, 0, 0, 0, 3, -8'sd2);
        push_op(MODE_DUP, 0, 0, 0, 3, 8'sd127);
        push_op(MODE_STD, 0, 0, 0, 0, 0);
        push_op(MODE_STD, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h0000_0001, 0, 0);
        push_op(MODE_UNUSED_LO, 32'h1234_5678, 0, 0, 0, 0);
        push_op(MODE_UNUSED_HI, 32'h1234_5678, 0, 0, 0, 0);
        push_op(MODE_CLOSE, 0, 0, 0, 0, 0);
        push_op(MODE_GET, 0, 0, 0, 0, 0);

        for (int i = 0; pending_ops.size() < RANDOM_OPS + 25; i++) begin
            if (i == 100 || $urandom_range(99) == 0)
                fill_table_burst();
            else if (i == 250 || $urandom_range(149) == 0)
                saturate_count_burst();
            else
                random_op();
        end
    endtask

    // Mostly short gaps, a few long ones, and idle-free stretches now and then.
    function automatic int next_gap(int side);
        int r;
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(39) == 0)
            quiet_left[side] = $urandom_range(30, 100);
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ---------------- request driver ----------------
    always @(negedge i_clk) begin : drive_requests
        t_table_op op;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_taken) begin
            if (req_gap > 0) begin
                req_bus.valid <= 1'b0;
                req_gap--;
            end else if (pending_ops.size() > 0) begin
                op = pending_ops.pop_front();
                req_bus.mode          <= op.mode;
                req_bus.handle        <= op.h0;
                req_bus.second_handle <= op.h1;
                req_bus.third_handle  <= op.h2;
                req_bus.slot_index    <= op.src;
                req_bus.target_index  <= op.tgt;
                req_bus.valid         <= 1'b1;
                req_gap = next_gap(SIDE_REQ);
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // ---------------- response backpressure ----------------
    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_stall == 0 && (rsp_taken || $urandom_range(19) == 0))
                rsp_stall = next_gap(SIDE_RSP);
            if (rsp_stall > 0) begin
                rsp_bus.ready <= 1'b0;
                rsp_stall--;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge i_clk) begin : check_replies
        t_table_op    op;
        t_table_reply want;
        t_table_reply got;
        req_taken <= i_rst_n && req_bus.valid && req_bus.ready;
        rsp_taken <= i_rst_n && rsp_bus.valid && rsp_bus.ready;
        if (i_rst_n && req_bus.valid && req_bus.ready) begin
            op.mode = req_bus.mode;
            op.h0   = req_bus.handle;
            op.h1   = req_bus.second_handle;
            op.h2   = req_bus.third_handle;
            op.src  = req_bus.slot_index;
            op.tgt  = req_bus.target_index;
            reply_q.push_back(apply_table_op(op));
            n_req++;
        end
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got.status = t_status'(rsp_bus.status);
            got.index  = rsp_bus.result_index;
            got.rd     = rsp_bus.read_handle;
            got.total  = rsp_bus.open_total;
            n_rsp++;
            if (got.status == ST_FULL)
                n_full++;
            if (got.total == COUNT_MAX)
                n_at_max++;
            if (reply_q.size() == 0) begin
                note_mismatch("response with no request outstanding");
            end else begin
                want = reply_q.pop_front();
                if (got !== want)
                    note_mismatch($sformatf(
                        "rsp %0d: exp st=%0d idx=%0d rd=%h cnt=%0d, got st=%0d idx=%0d rd=%h cnt=%0d",
                        n_rsp, want.status, want.index, want.rd, want.total,
                        got.status, got.index, got.rd, got.total));
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.mode          = '0;
        req_bus.handle        = '0;
        req_bus.second_handle = '0;
        req_bus.third_handle  = '0;
        req_bus.slot_index    = '0;
        req_bus.target_index  = '0;
        rsp_bus.ready         = 1'b0;
        req_taken             = 1'b0;
        rsp_taken             = 1'b0;
        req_gap               = 0;
        rsp_stall             = 0;
        quiet_left[SIDE_REQ]  = 0;
        quiet_left[SIDE_RSP]  = 0;
        n_req                 = 0;
        n_rsp                 = 0;
        n_full                = 0;
        n_at_max              = 0;
        mismatches            = 0;
        foreach (table_shadow[i])
            table_shadow[i] = '0;
        open_shadow = '0;

        build_stimulus();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || req_bus.valid || reply_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Ran %0d transactions (alloc/get/free/dup/close/set-standard, bad modes)",
                 n_req);
        $display("Checked %0d responses: %0d table-full, %0d at count limit, %0d mismatches",
                 n_rsp, n_full, n_at_max, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout: %0d requests sent, %0d responses seen", n_req, n_rsp);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
